@@ rtl/assert_macros.svh @@
// Assertion macros shared by the polynomial ALU modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("property violated");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("property violated");

`endif

@@ rtl/gf2p_pkg.sv @@
// Types and constants of the GF(2) polynomial ALU.
package gf2p_pkg;

    localparam int OPERAND_BITS    = 32;
    localparam int RESULT_BITS     = 63;
    localparam int DEGREE_BITS     = 7;
    localparam int PROD_BITS       = 2 * OPERAND_BITS - 1;
    localparam int IDX_BITS        = $clog2(OPERAND_BITS);
    localparam int DIV_STAGES      = 4;
    localparam int STAGE_BITS      = $clog2(DIV_STAGES);
    localparam int STEPS_PER_STAGE = (OPERAND_BITS + DIV_STAGES - 1) / DIV_STAGES;
    localparam int GROUP_BITS      = 8;
    localparam int GROUPS          = (RESULT_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int PAD_BITS        = GROUPS * GROUP_BITS;
    localparam int GROUP_IDX_BITS  = $clog2(GROUP_BITS);
    localparam int GROUP_SEL_BITS  = $clog2(GROUPS);
    localparam int DEG_IDX_BITS    = GROUP_SEL_BITS + GROUP_IDX_BITS;

    // degree of the zero polynomial, -1 in two's complement
    localparam logic [DEGREE_BITS-1:0] DEG_NONE = '1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_MOD = 2'd2
    } t_opcode;

    typedef logic [OPERAND_BITS-1:0] t_word;
    typedef logic [PROD_BITS-1:0]    t_prod;

    // one word in flight through the multiply / divide stages
    typedef struct packed {
        t_opcode op;
        t_word   a;
        t_word   b;
        t_word   hot;   // one-hot of the divisor's leading coefficient
        t_word   rem;   // running remainder
        t_prod   acc;   // running carry-less product
    } t_lane;

    typedef struct packed {
        logic [RESULT_BITS-1:0] result;
        logic                   dz;
    } t_res;

endpackage

@@ rtl/gf2p_step.sv @@
// One pipeline stage: a slice of the carry-less product and of the long division.
`include "assert_macros.svh"

module gf2p_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [gf2p_pkg::STAGE_BITS-1:0] i_stage,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  gf2p_pkg::t_lane                 i_lane,
    input  logic                            i_ready_next,
    output logic                            o_valid,
    output gf2p_pkg::t_lane                 o_lane
);

    logic            r_valid;
    gf2p_pkg::t_lane r_lane;
    gf2p_pkg::t_lane n_lane;

    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;
    assign o_lane  = r_lane;

    always_comb begin
        int                            j;
        logic [gf2p_pkg::IDX_BITS-1:0] ja;
        logic [gf2p_pkg::IDX_BITS-1:0] jd;
        gf2p_pkg::t_word               rem;
        n_lane = i_lane;
        for (int k = 0; k < gf2p_pkg::STEPS_PER_STAGE; k++) begin
            j  = int'(i_stage) * gf2p_pkg::STEPS_PER_STAGE + k;
            ja = gf2p_pkg::IDX_BITS'(j);
            jd = gf2p_pkg::IDX_BITS'(gf2p_pkg::OPERAND_BITS - 1 - j);
            if (j < gf2p_pkg::OPERAND_BITS) begin
                if (n_lane.a[ja]) begin
                    n_lane.acc = n_lane.acc ^
                        (gf2p_pkg::PROD_BITS'(n_lane.b) << ja);
                end
                // bring down the next dividend bit, reduce if it reaches deg(b)
                rem = {n_lane.rem[gf2p_pkg::OPERAND_BITS-2:0], n_lane.a[jd]};
                if (|(rem & n_lane.hot)) begin
                    rem = rem ^ n_lane.b;
                end
                n_lane.rem = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_valid && !i_ready_next,
        r_valid && r_lane == $past(r_lane))
    `ASSERT_IMPL(a_hot_matches_divisor, i_clk, i_rst_n, r_valid,
        $onehot0(r_lane.hot) && ((r_lane.hot == '0) == (r_lane.b == '0)))

endmodule

@@ rtl/gf2p_degree.sv @@
// Two-stage leading-coefficient search that yields the result degree.
`include "assert_macros.svh"

module gf2p_degree (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  gf2p_pkg::t_res                   i_res,
    input  logic                             i_ready_next,
    output logic                             o_valid,
    output gf2p_pkg::t_res                   o_res,
    output logic [gf2p_pkg::DEGREE_BITS-1:0] o_degree
);

    logic                                  r_va;
    gf2p_pkg::t_res                        r_res_a;
    logic [gf2p_pkg::GROUPS-1:0]           r_nz;
    logic [gf2p_pkg::GROUP_IDX_BITS-1:0]   r_idx [gf2p_pkg::GROUPS];
    logic [gf2p_pkg::GROUPS-1:0]           n_nz;
    logic [gf2p_pkg::GROUP_IDX_BITS-1:0]   n_idx [gf2p_pkg::GROUPS];

    logic                                  r_vb;
    gf2p_pkg::t_res                        r_res_b;
    logic [gf2p_pkg::DEGREE_BITS-1:0]      r_deg;
    logic [gf2p_pkg::DEGREE_BITS-1:0]      n_deg;

    logic                                  w_rdy_a;
    logic                                  w_rdy_b;
    logic [gf2p_pkg::PAD_BITS-1:0]         w_padded;

    assign w_rdy_b  = !r_vb || i_ready_next;
    assign w_rdy_a  = !r_va || w_rdy_b;
    assign o_ready  = w_rdy_a;
    assign o_valid  = r_vb;
    assign o_res    = r_res_b;
    assign o_degree = r_deg;
    assign w_padded = gf2p_pkg::PAD_BITS'(i_res.result);

    // per byte: any bit set, and the highest set bit within it
    always_comb begin
        for (int g = 0; g < gf2p_pkg::GROUPS; g++) begin
            n_nz[g]  = |w_padded[g*gf2p_pkg::GROUP_BITS +: gf2p_pkg::GROUP_BITS];
            n_idx[g] = '0;
            for (int k = 0; k < gf2p_pkg::GROUP_BITS; k++) begin
                if (w_padded[g*gf2p_pkg::GROUP_BITS + k]) begin
                    n_idx[g] = gf2p_pkg::GROUP_IDX_BITS'(k);
                end
            end
        end
    end

    always_comb begin
        n_deg = gf2p_pkg::DEG_NONE;
        for (int g = 0; g < gf2p_pkg::GROUPS; g++) begin
            if (r_nz[g]) begin
                n_deg = gf2p_pkg::DEGREE_BITS'({gf2p_pkg::GROUP_SEL_BITS'(g), r_idx[g]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_res_a <= i_res;
            r_nz    <= n_nz;
            r_idx   <= n_idx;
        end
        if (w_rdy_b && r_va) begin
            r_res_b <= r_res_a;
            r_deg   <= n_deg;
        end
    end

    `ASSERT_IMPL(a_degree_is_top_bit, i_clk, i_rst_n,
        r_vb && r_deg != gf2p_pkg::DEG_NONE,
        (r_res_b.result >> r_deg[gf2p_pkg::DEG_IDX_BITS-1:0]) == gf2p_pkg::RESULT_BITS'(1))
    `ASSERT_IMPL(a_none_means_zero, i_clk, i_rst_n,
        r_vb && r_deg == gf2p_pkg::DEG_NONE, r_res_b.result == '0)

endmodule

@@ rtl/gf2_polynomial_alu.sv @@
// Top level of the GF(2) polynomial ALU: add, carry-less multiply and remainder.
//
// Takes one word per cycle while o_stall is low and returns one result word per
// input, in order: an input register that finds the divisor's leading coefficient,
// four stages that each fold in a quarter of the operand bits (eight partial
// products and eight long-division steps), and two stages that locate the highest
// set coefficient for the degree. Every stage holds its word independently, so a
// stall at the output only stops the stages that are full; bubbles upstream still
// fill. Mod by a zero divisor returns operand a with divide_by_zero set, a zero
// result reports degree -1, and opcode three gives zero.
`include "assert_macros.svh"

module gf2_polynomial_alu (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_opcode,
    input  logic [31:0]                      i_operand_a,
    input  logic [31:0]                      i_operand_b,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [gf2p_pkg::RESULT_BITS-1:0] o_result,
    output logic [gf2p_pkg::DEGREE_BITS-1:0] o_result_degree,
    output logic                             o_divide_by_zero
);

    localparam int NS = gf2p_pkg::DIV_STAGES;

    logic            r_v0;
    gf2p_pkg::t_lane r_lane0;
    gf2p_pkg::t_lane n_lane0;
    gf2p_pkg::t_word w_rb;
    gf2p_pkg::t_word w_iso;
    gf2p_pkg::t_word w_hot;

    gf2p_pkg::t_lane w_lane  [NS+1];
    logic            w_valid [NS+1];
    logic            w_ready [NS+1];

    gf2p_pkg::t_res  w_sel;
    gf2p_pkg::t_res  w_out;
    logic            w_rdy0;

    // leading coefficient of b: isolate the lowest set bit of the bit-reversed word
    always_comb begin
        for (int k = 0; k < gf2p_pkg::OPERAND_BITS; k++) begin
            w_rb[k] = i_operand_b[gf2p_pkg::OPERAND_BITS-1-k];
        end
        w_iso = w_rb & (~w_rb + gf2p_pkg::t_word'(1));
        for (int k = 0; k < gf2p_pkg::OPERAND_BITS; k++) begin
            w_hot[k] = w_iso[gf2p_pkg::OPERAND_BITS-1-k];
        end
    end

    always_comb begin
        n_lane0.op  = gf2p_pkg::t_opcode'(i_opcode);
        n_lane0.a   = i_operand_a[gf2p_pkg::OPERAND_BITS-1:0];
        n_lane0.b   = i_operand_b[gf2p_pkg::OPERAND_BITS-1:0];
        n_lane0.hot = w_hot;
        n_lane0.rem = '0;
        n_lane0.acc = '0;
    end

    assign w_rdy0  = !r_v0 || w_ready[0];
    assign o_stall = !w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_rdy0) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_lane0 <= n_lane0;
        end
    end

    assign w_lane[0]  = r_lane0;
    assign w_valid[0] = r_v0;

    for (genvar s = 0; s < NS; s++) begin : g_step
        gf2p_step u_step (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_stage      (gf2p_pkg::STAGE_BITS'(s)),
            .i_valid      (w_valid[s]),
            .o_ready      (w_ready[s]),
            .i_lane       (w_lane[s]),
            .i_ready_next (w_ready[s+1]),
            .o_valid      (w_valid[s+1]),
            .o_lane       (w_lane[s+1])
        );
    end

    always_comb begin
        case (w_lane[NS].op)
            gf2p_pkg::OP_ADD: w_sel.result =
                gf2p_pkg::RESULT_BITS'(w_lane[NS].a ^ w_lane[NS].b);
            gf2p_pkg::OP_MUL: w_sel.result = gf2p_pkg::RESULT_BITS'(w_lane[NS].acc);
            gf2p_pkg::OP_MOD: w_sel.result = gf2p_pkg::RESULT_BITS'(w_lane[NS].rem);
            default:          w_sel.result = '0;
        endcase
        w_sel.dz = (w_lane[NS].op == gf2p_pkg::OP_MOD) && (w_lane[NS].b == '0);
    end

    gf2p_degree u_degree (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NS]),
        .o_ready      (w_ready[NS]),
        .i_res        (w_sel),
        .i_ready_next (!i_stall),
        .o_valid      (o_valid),
        .o_res        (w_out),
        .o_degree     (o_result_degree)
    );

    assign o_result         = w_out.result;
    assign o_divide_by_zero = w_out.dz;

    // with a zero divisor the result is operand a, so it fits the operand width
    `ASSERT_IMPL(a_dz_degree_fits, i_clk, i_rst_n, o_valid && o_divide_by_zero,
        o_result_degree == gf2p_pkg::DEG_NONE ||
        o_result_degree < gf2p_pkg::DEGREE_BITS'(gf2p_pkg::OPERAND_BITS))

endmodule

@@ verif/tb_gf2_polynomial_alu.sv @@
// Testbench for the GF(2) polynomial ALU: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module tb_gf2_polynomial_alu;

    localparam logic [1:0] OPC_SPARE   = 2'd3;   // unused opcode, gives zero
    localparam int         RANDOM_WORDS = 1625;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         HOLD_CYCLES  = 300;

    typedef struct {
        logic [1:0]      op;
        gf2p_pkg::t_word a;
        gf2p_pkg::t_word b;
        int              gap;     // idle cycles before this word is offered
    } t_pending;

    typedef struct {
        logic [gf2p_pkg::RESULT_BITS-1:0] result;
        logic [gf2p_pkg::DEGREE_BITS-1:0] degree;
        logic                             dz;
    } t_poly_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    logic [1:0]                       i_opcode = 2'd0;
    logic [31:0]                      i_operand_a = '0;
    logic [31:0]                      i_operand_b = '0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    logic [gf2p_pkg::RESULT_BITS-1:0] o_result;
    logic [gf2p_pkg::DEGREE_BITS-1:0] o_result_degree;
    logic                             o_divide_by_zero;

    t_pending     pending_words[$];
    t_poly_result awaited_results[$];

    logic in_taken = 1'b0;
    logic hold_active = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   rx_calm_left = 0;
    int   words_in = 0;
    int   mismatches = 0;
    int   cycles = 0;

    gf2_polynomial_alu i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result        (o_result),
        .o_result_degree (o_result_degree),
        .o_divide_by_zero(o_divide_by_zero)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_poly_result gf2_evaluate(logic [1:0] op, gf2p_pkg::t_word a,
                                                  gf2p_pkg::t_word b);
        t_poly_result                     r;
        logic [gf2p_pkg::RESULT_BITS-1:0] poly;
        gf2p_pkg::t_word                  rem;
        int                               db;
        int                               deg;
        poly = '0;
        r.dz = 1'b0;
        case (op)
            gf2p_pkg::OP_ADD: poly = gf2p_pkg::RESULT_BITS'(a ^ b);
            gf2p_pkg::OP_MUL: begin
                for (int i = 0; i < gf2p_pkg::OPERAND_BITS; i++)
                    if (a[i]) poly ^= gf2p_pkg::RESULT_BITS'(b) << i;
            end
            gf2p_pkg::OP_MOD: begin
                if (b == '0) begin
                    poly = gf2p_pkg::RESULT_BITS'(a);
                    r.dz = 1'b1;
                end else begin
                    db = -1;
                    for (int i = gf2p_pkg::OPERAND_BITS - 1; i >= 0; i--)
                        if (b[i] && db < 0) db = i;
                    rem = a;
                    for (int i = gf2p_pkg::OPERAND_BITS - 1; i >= db; i--)
                        if (rem[i]) rem ^= b << (i - db);
                    poly = gf2p_pkg::RESULT_BITS'(rem);
                end
            end
            default: poly = '0;
        endcase
        deg = -1;
        for (int i = 0; i < gf2p_pkg::RESULT_BITS; i++)
            if (poly[i]) deg = i;
        r.result = poly;
        r.degree = (deg < 0) ? gf2p_pkg::DEG_NONE : gf2p_pkg::DEGREE_BITS'(deg);
        return r;
    endfunction

    // operand shapes that stress degree finding and long division
    function automatic gf2p_pkg::t_word rand_poly();
        int              kind;
        gf2p_pkg::t_word p;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       p = '0;
            1:       p = '1;
            2:       p = gf2p_pkg::t_word'(1) << $urandom_range(0, gf2p_pkg::OPERAND_BITS - 1);
            3, 4:    p = gf2p_pkg::t_word'($urandom) >>
                         $urandom_range(0, gf2p_pkg::OPERAND_BITS - 1);
            default: p = gf2p_pkg::t_word'($urandom);
        endcase
        return p;
    endfunction

    task automatic queue_word(logic [1:0] op, gf2p_pkg::t_word a, gf2p_pkg::t_word b,
                              int gap);
        t_pending w;
        w.op  = op;
        w.a   = a;
        w.b   = b;
        w.gap = gap;
        pending_words = {pending_words, w};
    endtask

    // sender: new word only when the line is idle or the last word was taken
    always @(negedge i_clk) begin
        t_pending w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                i_opcode    <= w.op;
                i_operand_a <= w.a;
                i_operand_b <= w.b;
                i_valid     <= 1'b1;
                if (pending_words.size() != 0) gap_left = pending_words[0].gap;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, overridden by the long hold-off
    always @(negedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_active) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (rx_calm_left > 0) begin
                rx_calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55)      stall_left = 0;
                else if (r < 85) stall_left = $urandom_range(1, 3);
                else if (r < 96) stall_left = $urandom_range(4, 12);
                else if (r < 98) stall_left = $urandom_range(30, 80);
                else             rx_calm_left = $urandom_range(50, 300);
            end
        end
    end

    always @(posedge i_clk) begin
        t_poly_result e;
        cycles++;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            awaited_results = {awaited_results,
                               gf2_evaluate(i_opcode, i_operand_a, i_operand_b)};
            words_in++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: result %h degree %h dz %b",
                             o_result, o_result_degree, o_divide_by_zero);
            end else begin
                e = awaited_results.pop_front();
                if (o_result !== e.result || o_result_degree !== e.degree ||
                    o_divide_by_zero !== e.dz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: exp %h/%h/%b got %h/%h/%b",
                                 e.result, e.degree, e.dz,
                                 o_result, o_result_degree, o_divide_by_zero);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("gf2_polynomial_alu: mismatch");
            $finish;
        end
    end

    // long hold-offs so the pipe fills and pushes back on the sender
    initial begin
        while (words_in < 300) @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
        while (words_in < 1100) @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    initial begin
        logic [1:0] op;
        int         r;
        int         gap;
        int         calm_left;

        // directed: extremes, every opcode, zero results, mod by zero
        queue_word(gf2p_pkg::OP_ADD, 32'h0, 32'h0, 0);
        queue_word(gf2p_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_word(gf2p_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0, 0);
        queue_word(gf2p_pkg::OP_ADD, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 1);
        queue_word(gf2p_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_word(gf2p_pkg::OP_MUL, 32'h0, 32'hDEAD_BEEF, 0);
        queue_word(gf2p_pkg::OP_MUL, 32'h1, 32'h1, 0);
        queue_word(gf2p_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
        queue_word(gf2p_pkg::OP_MUL, 32'h8000_0001, 32'hFFFF_FFFF, 2);
        queue_word(gf2p_pkg::OP_MUL, 32'h3, 32'h3, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'h0, 32'h0, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'hFFFF_FFFF, 32'h0, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'h1234_5678, 32'h1, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'h0000_0013, 32'h8000_0000, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'hFFFF_FFFF, 32'h8000_0000, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'h8000_0000, 32'h0000_0003, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'h0, 32'h0000_011B, 0);
        queue_word(gf2p_pkg::OP_MOD, 32'hFFFF_FFFF, 32'h0000_011B, 3);
        queue_word(OPC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_word(OPC_SPARE, 32'h0, 32'h0, 0);

        calm_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      op = gf2p_pkg::OP_ADD;
            else if (r < 62) op = gf2p_pkg::OP_MUL;
            else if (r < 95) op = gf2p_pkg::OP_MOD;
            else             op = OPC_SPARE;
            if (calm_left > 0) begin
                calm_left--;
                gap = 0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60)      gap = 0;
                else if (r < 88) gap = $urandom_range(1, 3);
                else if (r < 96) gap = $urandom_range(4, 10);
                else if (r < 98) gap = $urandom_range(20, 60);
                else begin
                    gap = 0;
                    calm_left = $urandom_range(30, 200);
                end
            end
            queue_word(op, rand_poly(), rand_poly(), gap);
        end
        gap_left = pending_words[0].gap;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("gf2_polynomial_alu: match");
        else
            $display("gf2_polynomial_alu: mismatch");
        $finish;
    end

endmodule
